// File: rtl/core/rhfr_pkg.sv
`default_nettype none

package rhfr_pkg;

    localparam logic [15:0] RTP_HEADER_BYTES = 16'd12;
    localparam logic [15:0] FU_HEADER_POS    = 16'd13;
    localparam logic [15:0] PT_BYTE_POS      = 16'd1;
    localparam logic [15:0] INDEX_SAT        = 16'hFFFF;

    localparam logic [7:0] SPS_NAL_BYTE   = 8'h67;
    localparam logic [7:0] FUA_INDICATOR  = 8'h7C;
    localparam logic [7:0] NAL_HDR_BASE   = 8'h60;
    localparam logic [7:0] START_CODE_ONE = 8'h01;
    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam int         FU_END_BIT     = 6;
    localparam logic [6:0] PT_RESET       = 7'd96;
    localparam logic [1:0] START_CODE_LAST_CNT = 2'd3;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_SPS   = 2'd1,
        KIND_FUA   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_SC1  = 3'd1,
        ST_SPS  = 3'd2,
        ST_SC2  = 3'd3,
        ST_HDR  = 3'd4
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/rtp_h264_fua_reassembler.sv
`default_nettype none

// RTP H.264 FU-A reassembler. Datagram bytes enter on s_* (tlast on the final
// byte); the Annex-B stream leaves on m_* with tlast on the transaction that
// completes a unit and tuser low for a bare end marker. Payload bytes pass at
// one per cycle while the output is taken. The FU header that opens a unit
// holds the input while a sequencer emits start code, the stored SPS (at most
// SPS_MAX bytes) read from the SPS memory one entry per cycle while the output
// is taken, start code and the rebuilt NAL header. The SPS memory has no
// clearing pass; only committed entries are ever read.
module rtp_h264_fua_reassembler #(
    parameter int SPS_MAX = 48
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration: video_payload_type
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // datagram_end
    // output stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] byte_valid
    output logic            m_tlast    // unit_end
);

    localparam int AW = (SPS_MAX > 1) ? $clog2(SPS_MAX) : 1;
    localparam int LW = $clog2(SPS_MAX + 1);

    rhfr_pkg::state_t state_reg, state_next;
    rhfr_pkg::kind_t  kind_reg, kind_next, kind_eff;

    logic [6:0]    vpt_reg;
    logic [15:0]   byte_index_reg, byte_index_next;
    logic          tm_reg, tm_next;
    logic [LW-1:0] cap_reg, cap_next, cap_base;
    logic [LW-1:0] sps_length_reg, sps_length_next;
    logic          sps_ready_reg, sps_ready_next;
    logic          in_unit_reg, in_unit_next;
    logic [4:0]    unit_type_reg, unit_type_next;
    logic          end_frag_reg, end_frag_next;
    logic          hdr_last_reg, hdr_last_next;
    logic [1:0]    sc_cnt_reg, sc_cnt_next;
    logic [AW-1:0] sps_idx_reg, sps_idx_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_bv_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          acc;
    logic          push;
    logic [7:0]    push_byte;
    logic          push_bv;
    logic          push_last;
    logic          open_unit;
    logic          sps_last_idx;
    logic          ef;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == rhfr_pkg::ST_IDLE) && out_free;
    assign acc       = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_bv_reg;
    assign m_tlast  = out_last_reg;

    assign sps_last_idx = (LW'(sps_idx_reg) + LW'(1)) == sps_length_reg;

    rhfr_sps_ram #(
        .DEPTH (SPS_MAX),
        .AW    (AW)
    ) u_sps_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (sps_idx_next),
        .rdata (ram_rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rhfr_pkg::ST_IDLE:
            begin
                if (open_unit)
                begin
                    state_next = rhfr_pkg::ST_SC1;
                end
            end
            rhfr_pkg::ST_SC1:
            begin
                if (out_free && sc_cnt_reg == rhfr_pkg::START_CODE_LAST_CNT)
                begin
                    state_next = (sps_length_reg == '0) ? rhfr_pkg::ST_SC2
                                                        : rhfr_pkg::ST_SPS;
                end
            end
            rhfr_pkg::ST_SPS:
            begin
                if (out_free && sps_last_idx)
                begin
                    state_next = rhfr_pkg::ST_SC2;
                end
            end
            rhfr_pkg::ST_SC2:
            begin
                if (out_free && sc_cnt_reg == rhfr_pkg::START_CODE_LAST_CNT)
                begin
                    state_next = rhfr_pkg::ST_HDR;
                end
            end
            rhfr_pkg::ST_HDR:
            begin
                if (out_free)
                begin
                    state_next = rhfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rhfr_pkg::ST_IDLE;
            end
        endcase
    end

    // datagram parsing and emission
    always_comb
    begin
        kind_eff        = kind_reg;
        kind_next       = kind_reg;
        byte_index_next = byte_index_reg;
        tm_next         = tm_reg;
        cap_base        = cap_reg;
        cap_next        = cap_reg;
        sps_length_next = sps_length_reg;
        sps_ready_next  = sps_ready_reg;
        in_unit_next    = in_unit_reg;
        unit_type_next  = unit_type_reg;
        end_frag_next   = end_frag_reg;
        hdr_last_next   = hdr_last_reg;
        sc_cnt_next     = sc_cnt_reg;
        sps_idx_next    = '0;
        open_unit       = 1'b0;
        ef              = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cap_base[AW-1:0];
        push            = 1'b0;
        push_byte       = rhfr_pkg::START_CODE_ZERO;
        push_bv         = 1'b1;
        push_last       = 1'b0;

        unique case (state_reg)
            rhfr_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (byte_index_reg == rhfr_pkg::PT_BYTE_POS)
                    begin
                        tm_next = (s_tdata[6:0] == vpt_reg);
                    end
                    if (byte_index_reg == rhfr_pkg::RTP_HEADER_BYTES)
                    begin
                        kind_eff = rhfr_pkg::KIND_OTHER;
                        if (tm_reg && s_tdata == rhfr_pkg::SPS_NAL_BYTE)
                        begin
                            kind_eff = rhfr_pkg::KIND_SPS;
                            cap_base = '0;
                        end
                        else if (tm_reg && s_tdata == rhfr_pkg::FUA_INDICATOR
                                 && sps_ready_reg)
                        begin
                            kind_eff = rhfr_pkg::KIND_FUA;
                        end
                    end
                    cap_next  = cap_base;
                    ram_waddr = cap_base[AW-1:0];

                    if (kind_eff == rhfr_pkg::KIND_SPS
                        && byte_index_reg >= rhfr_pkg::RTP_HEADER_BYTES)
                    begin
                        if (cap_base < LW'(SPS_MAX))
                        begin
                            ram_we   = 1'b1;
                            cap_next = cap_base + LW'(1);
                        end
                    end
                    else if (kind_eff == rhfr_pkg::KIND_FUA
                             && byte_index_reg == rhfr_pkg::FU_HEADER_POS)
                    begin
                        if (!in_unit_reg)
                        begin
                            // opening fragment: end test compares the type with itself
                            open_unit      = 1'b1;
                            unit_type_next = s_tdata[4:0];
                            ef             = s_tdata[rhfr_pkg::FU_END_BIT];
                            in_unit_next   = !(s_tlast && ef);
                            hdr_last_next  = s_tlast && ef;
                            sc_cnt_next    = '0;
                        end
                        else
                        begin
                            ef = s_tdata[rhfr_pkg::FU_END_BIT]
                                 && (s_tdata[4:0] == unit_type_reg);
                            if (s_tlast && ef)
                            begin
                                // bare end marker
                                push         = 1'b1;
                                push_byte    = rhfr_pkg::START_CODE_ZERO;
                                push_bv      = 1'b0;
                                push_last    = 1'b1;
                                in_unit_next = 1'b0;
                            end
                        end
                        end_frag_next = ef;
                    end
                    else if (kind_eff == rhfr_pkg::KIND_FUA
                             && byte_index_reg > rhfr_pkg::FU_HEADER_POS
                             && in_unit_reg)
                    begin
                        push      = 1'b1;
                        push_byte = s_tdata;
                        push_last = s_tlast && end_frag_reg;
                        if (s_tlast && end_frag_reg)
                        begin
                            in_unit_next = 1'b0;
                        end
                    end

                    kind_next = kind_eff;
                    if (s_tlast)
                    begin
                        if (kind_eff == rhfr_pkg::KIND_SPS)
                        begin
                            sps_length_next = cap_next;
                            sps_ready_next  = 1'b1;
                        end
                        byte_index_next = '0;
                        tm_next         = 1'b0;
                        kind_next       = rhfr_pkg::KIND_OTHER;
                        end_frag_next   = 1'b0;
                    end
                    else if (byte_index_reg < rhfr_pkg::INDEX_SAT)
                    begin
                        byte_index_next = byte_index_reg + 16'd1;
                    end
                end
            end
            rhfr_pkg::ST_SC1,
            rhfr_pkg::ST_SC2:
            begin
                push      = out_free;
                push_byte = (sc_cnt_reg == rhfr_pkg::START_CODE_LAST_CNT)
                            ? rhfr_pkg::START_CODE_ONE : rhfr_pkg::START_CODE_ZERO;
                if (out_free)
                begin
                    sc_cnt_next = sc_cnt_reg + 2'd1;
                end
            end
            rhfr_pkg::ST_SPS:
            begin
                // memory read address runs one step ahead, so ram_rdata
                // always holds the entry at sps_idx_reg
                push         = out_free;
                push_byte    = ram_rdata;
                sps_idx_next = sps_idx_reg;
                if (out_free)
                begin
                    sps_idx_next = sps_last_idx ? '0 : sps_idx_reg + AW'(1);
                end
            end
            rhfr_pkg::ST_HDR:
            begin
                push      = out_free;
                push_byte = rhfr_pkg::NAL_HDR_BASE | {3'b000, unit_type_reg};
                push_last = hdr_last_reg;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rhfr_pkg::ST_IDLE;
            kind_reg       <= rhfr_pkg::KIND_OTHER;
            vpt_reg        <= rhfr_pkg::PT_RESET;
            byte_index_reg <= '0;
            tm_reg         <= 1'b0;
            cap_reg        <= '0;
            sps_length_reg <= '0;
            sps_ready_reg  <= 1'b0;
            in_unit_reg    <= 1'b0;
            unit_type_reg  <= '0;
            end_frag_reg   <= 1'b0;
            hdr_last_reg   <= 1'b0;
            sc_cnt_reg     <= '0;
            sps_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            byte_index_reg <= byte_index_next;
            tm_reg         <= tm_next;
            cap_reg        <= cap_next;
            sps_length_reg <= sps_length_next;
            sps_ready_reg  <= sps_ready_next;
            in_unit_reg    <= in_unit_next;
            unit_type_reg  <= unit_type_next;
            end_frag_reg   <= end_frag_next;
            hdr_last_reg   <= hdr_last_next;
            sc_cnt_reg     <= sc_cnt_next;
            sps_idx_reg    <= sps_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                vpt_reg <= cfg_data;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_byte_reg <= push_byte;
            out_bv_reg   <= push_bv;
            out_last_reg <= push_last;
        end
    end

`ifndef NO_ASSERTIONS
    // an opening FU header starts the prefix sequence
    a_open_starts_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        open_unit |=> (state_reg == rhfr_pkg::ST_SC1))
        else $error("opening header did not start prefix");

    // SPS readout stays within the committed length
    a_sps_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rhfr_pkg::ST_SPS) |-> (LW'(sps_idx_reg) < sps_length_reg))
        else $error("SPS read past committed length");

    // a transaction without data is only ever a zero end marker
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == rhfr_pkg::START_CODE_ZERO))
        else $error("malformed bare end marker");

    // capture count never passes the store size
    a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg <= LW'(SPS_MAX)) && (sps_length_reg <= LW'(SPS_MAX)))
        else $error("SPS capture count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rhfr_sps_ram.sv
`default_nettype none

module rhfr_sps_ram #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
